@@ hdl/itc_pkg.sv @@
// ----------------------------------------------------------------------------
// itc_pkg: shared types and constants of the toroidal convolution engine
// Request codes, register indexes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package itc_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_KDIM = 7;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 12;
  localparam int CFG_W  = 16;
  localparam int CFGI_W = 3;

  typedef enum logic [1:0] {
    REQ_KERNEL = 2'd0,
    REQ_GRID   = 2'd1,
    REQ_RUN    = 2'd2,
    REQ_READ   = 2'd3
  } req_t;

  typedef enum logic [CFGI_W-1:0] {
    CFG_GRID_ROWS   = 3'd0,
    CFG_GRID_COLS   = 3'd1,
    CFG_KERNEL_ROWS = 3'd2,
    CFG_KERNEL_COLS = 3'd3,
    CFG_ITERATIONS  = 3'd4
  } cfg_idx_t;

  localparam logic [6:0]  RST_GRID_ROWS   = 7'd64;
  localparam logic [6:0]  RST_GRID_COLS   = 7'd64;
  localparam logic [2:0]  RST_KERNEL_ROWS = 3'd3;
  localparam logic [2:0]  RST_KERNEL_COLS = 3'd3;
  localparam logic [15:0] RST_ITERATIONS  = 16'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CELL_INIT,
    ST_TAP_RD,
    ST_TAP_MUL,
    ST_TAP_ACC,
    ST_DIV,
    ST_DIV_WAIT,
    ST_STORE,
    ST_COPY_RD,
    ST_COPY_WR
  } state_t;

  // Control strobes from the sequencer to the memories
  typedef struct packed {
    logic busy;
    logic next_we;
    logic grid_we;
  } seq_ctl_t;

endpackage

@@ hdl/itc_div.sv @@
// ----------------------------------------------------------------------------
// itc_div: iterative signed-by-unsigned divider
// Restoring division, one quotient bit per cycle, truncation toward zero.
// ----------------------------------------------------------------------------
module itc_div #(
  parameter int DW = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [itc_pkg::DATA_W-1:0]  dividend,
  input  logic [DW-1:0]               divisor,
  output logic                        done,
  output logic [itc_pkg::DATA_W-1:0]  quotient
);

  localparam int N  = itc_pkg::DATA_W;
  localparam int NW = $clog2(N);

  logic [N-1:0]  mag;
  logic [N-1:0]  q;
  logic [DW:0]   rem;
  logic [NW-1:0] cnt;
  logic          run;
  logic          neg;
  logic [DW:0]   shifted;
  logic          ge;

  assign shifted = {rem[DW-1:0], mag[N-1]};
  assign ge      = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        rem <= '0;
        neg <= dividend[N-1];
        mag <= dividend[N-1] ? (~dividend + 1'b1) : dividend;
      end else if (run) begin
        rem <= ge ? (shifted - {1'b0, divisor}) : shifted;
        q   <= {q[N-2:0], ge};
        mag <= {mag[N-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == NW'(N - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? (~q + 1'b1) : q;

endmodule

@@ hdl/itc_seq.sv @@
// ----------------------------------------------------------------------------
// itc_seq: convolution pass sequencer
// Walks cells, kernel taps with torus wrap, one multiply-accumulate per tap,
// divides each sum, stores it, then copies the new grid back.
// ----------------------------------------------------------------------------
module itc_seq #(
  parameter int MAX_ROWS = itc_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = itc_pkg::DEF_MAX_COLS,
  parameter int MAX_KDIM = itc_pkg::DEF_MAX_KDIM,
  parameter int GAW      = 12,
  parameter int KAW      = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [6:0]                  grid_rows,
  input  logic [6:0]                  grid_cols,
  input  logic [2:0]                  kernel_rows,
  input  logic [2:0]                  kernel_cols,
  input  logic [15:0]                 iterations,
  input  logic [itc_pkg::DATA_W-1:0]  grid_q,
  input  logic [itc_pkg::DATA_W-1:0]  kern_q,
  output itc_pkg::seq_ctl_t           ctl,
  output logic [GAW-1:0]              grid_raddr,
  output logic [GAW-1:0]              grid_waddr,
  output logic [KAW-1:0]              kern_raddr,
  output logic [GAW-1:0]              next_addr,
  output logic [itc_pkg::DATA_W-1:0]  next_wdata
);

  localparam int MAXD = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int PW   = $clog2(MAXD + 1);
  localparam int KW   = $clog2(MAX_KDIM + 1);
  localparam int DW   = $clog2(MAX_KDIM * MAX_KDIM + 1);
  localparam int HMAX = (MAX_KDIM - 1) / 2;

  itc_pkg::state_t state, state_next;

  logic [PW-1:0]  rows, cols, r, c, gr, gc, gc0;
  logic [KW-1:0]  kr, kc, ti, tj, h1, h2;
  logic [15:0]    iters, pass;
  logic [GAW:0]   ncell, cp;
  logic [itc_pkg::DATA_W-1:0] prod, acc;
  logic           div_done;
  logic [itc_pkg::DATA_W-1:0] div_q;
  logic           last_tj, last_ti, last_c, last_r, last_cp;

  function automatic logic [PW-1:0] wrap_back(logic [PW-1:0] pos, logic [KW-1:0] h,
                                              logic [PW-1:0] size);
    logic [PW-1:0] p;
    p = pos;
    for (int k = 0; k < HMAX; k++) begin
      if (KW'(k) < h) p = (p == '0) ? size - 1'b1 : p - 1'b1;
    end
    return p;
  endfunction

  function automatic logic [PW-1:0] clamp_dim(logic [6:0] v, int hi);
    if (v == '0) return PW'(1);
    if (32'(v) > hi) return PW'(hi);
    return PW'(v);
  endfunction

  function automatic logic [KW-1:0] clamp_k(logic [2:0] v);
    if (v == '0) return KW'(1);
    if (32'(v) > MAX_KDIM) return KW'(MAX_KDIM);
    return KW'(v);
  endfunction

  assign h1      = (kr - 1'b1) >> 1;
  assign h2      = (kc - 1'b1) >> 1;
  assign last_tj = (tj == {h2, 1'b0} >> 0) || (tj == KW'(2 * h2));
  assign last_ti = (ti == KW'(2 * h1));
  assign last_c  = (c == cols - 1'b1);
  assign last_r  = (r == rows - 1'b1);
  assign last_cp = (cp == ncell - 1'b1);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      itc_pkg::ST_IDLE:      if (start && iterations != '0) state_next = itc_pkg::ST_CELL_INIT;
      itc_pkg::ST_CELL_INIT: state_next = itc_pkg::ST_TAP_RD;
      itc_pkg::ST_TAP_RD:    state_next = itc_pkg::ST_TAP_MUL;
      itc_pkg::ST_TAP_MUL:   state_next = itc_pkg::ST_TAP_ACC;
      itc_pkg::ST_TAP_ACC:
        state_next = (last_tj && last_ti) ? itc_pkg::ST_DIV : itc_pkg::ST_TAP_RD;
      itc_pkg::ST_DIV:       state_next = itc_pkg::ST_DIV_WAIT;
      itc_pkg::ST_DIV_WAIT:  if (div_done) state_next = itc_pkg::ST_STORE;
      itc_pkg::ST_STORE:
        state_next = (last_c && last_r) ? itc_pkg::ST_COPY_RD : itc_pkg::ST_CELL_INIT;
      itc_pkg::ST_COPY_RD:   state_next = itc_pkg::ST_COPY_WR;
      itc_pkg::ST_COPY_WR: begin
        if (!last_cp) state_next = itc_pkg::ST_COPY_RD;
        else if (pass + 1'b1 == iters) state_next = itc_pkg::ST_IDLE;
        else state_next = itc_pkg::ST_CELL_INIT;
      end
      default:               state_next = itc_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl.busy    = (state != itc_pkg::ST_IDLE);
    ctl.next_we = (state == itc_pkg::ST_STORE);
    ctl.grid_we = (state == itc_pkg::ST_COPY_WR);
    grid_raddr  = GAW'(gr) * GAW'(cols) + GAW'(gc);
    kern_raddr  = KAW'(ti) * KAW'(kc) + KAW'(tj);
    grid_waddr  = GAW'(cp);
    next_addr   = (state == itc_pkg::ST_STORE) ? GAW'(r) * GAW'(cols) + GAW'(c) : GAW'(cp);
    next_wdata  = div_q;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= itc_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      itc_pkg::ST_IDLE: begin
        rows  <= clamp_dim(grid_rows, MAX_ROWS);
        cols  <= clamp_dim(grid_cols, MAX_COLS);
        kr    <= clamp_k(kernel_rows);
        kc    <= clamp_k(kernel_cols);
        iters <= iterations;
        ncell <= (GAW + 1)'(clamp_dim(grid_rows, MAX_ROWS)) *
                 (GAW + 1)'(clamp_dim(grid_cols, MAX_COLS));
        pass  <= '0;
        r     <= '0;
        c     <= '0;
        cp    <= '0;
      end
      itc_pkg::ST_CELL_INIT: begin
        gr  <= wrap_back(r, h1, rows);
        gc  <= wrap_back(c, h2, cols);
        gc0 <= wrap_back(c, h2, cols);
        ti  <= '0;
        tj  <= '0;
        acc <= '0;
      end
      itc_pkg::ST_TAP_MUL: prod <= itc_pkg::DATA_W'(grid_q * kern_q);
      itc_pkg::ST_TAP_ACC: begin
        acc <= acc + prod;
        if (last_tj) begin
          tj <= '0;
          ti <= ti + 1'b1;
          gc <= gc0;
          gr <= (gr == rows - 1'b1) ? '0 : gr + 1'b1;
        end else begin
          tj <= tj + 1'b1;
          gc <= (gc == cols - 1'b1) ? '0 : gc + 1'b1;
        end
      end
      itc_pkg::ST_STORE: begin
        if (last_c) begin
          c <= '0;
          r <= last_r ? '0 : r + 1'b1;
        end else begin
          c <= c + 1'b1;
        end
        cp <= '0;
      end
      itc_pkg::ST_COPY_WR: begin
        cp <= cp + 1'b1;
        if (last_cp) pass <= pass + 1'b1;
      end
      default: ;
    endcase
  end

  itc_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == itc_pkg::ST_DIV),
    .dividend (acc),
    .divisor  (DW'(kr) * DW'(kc)),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

@@ hdl/iterated_toroidal_convolution_top.sv @@
// ----------------------------------------------------------------------------
// iterated_toroidal_convolution_top: iterated 2-D circular convolution engine
// Holds kernel, grid and scratch grid memories and the request/result streams.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one beat per request. s_tuser holds the request kind
//   (kernel write, grid write, run, read); s_tdata holds cell_index and
//   write_value. Master stream m_*: one beat per read request, the cell value.
//   User writes registers via cfg_we/cfg_index/cfg_data only while idle; unchecked.
// Timing:
//   Kernel and grid writes land on the accepting edge. A read is registered in
//   rd_pend with the grid memory output, then moves to m_tdata once the output
//   register is free. Per pass, each tap of each cell passes read, multiply and
//   accumulate on the shared multiply-accumulate; the serial divider runs per
//   cell; then the scratch grid is copied back into the grid at one memory port.
//   s_tready stays low while a run is in progress or a read waits.
// Reset:
//   rst clears control state and restores register defaults (64 x 64 grid,
//   3 x 3 kernel, one pass). Memory contents are undefined until written.
// Stalls:
//   A read result holds in the output register until taken; one more read
//   may be taken behind it, and then requests wait until the register frees.
// ----------------------------------------------------------------------------
module iterated_toroidal_convolution_top #(
  parameter int MAX_ROWS = itc_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = itc_pkg::DEF_MAX_COLS,
  parameter int MAX_KDIM = itc_pkg::DEF_MAX_KDIM
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [47:0]                s_tdata,   // cell_index[11:0], write_value[43:12], 0
  input  logic [1:0]                 s_tuser,   // req_type[1:0]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [31:0]                m_tdata,   // read_value[31:0]
  input  logic                       cfg_we,
  input  logic [itc_pkg::CFGI_W-1:0] cfg_index,
  input  logic [itc_pkg::CFG_W-1:0]  cfg_data
);

  localparam int GDEPTH = MAX_ROWS * MAX_COLS;
  localparam int KDEPTH = MAX_KDIM * MAX_KDIM;
  localparam int GAW    = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
  localparam int KAW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;

  logic [6:0]  grid_rows, grid_cols;
  logic [2:0]  kernel_rows, kernel_cols;
  logic [15:0] iterations;

  logic [itc_pkg::DATA_W-1:0] grid_mem [GDEPTH];
  logic [itc_pkg::DATA_W-1:0] next_mem [GDEPTH];
  logic [itc_pkg::DATA_W-1:0] kern_mem [KDEPTH];
  logic [itc_pkg::DATA_W-1:0] grid_q, next_q, kern_q;

  itc_pkg::seq_ctl_t ctl;
  logic [GAW-1:0] seq_graddr, seq_gwaddr, next_addr;
  logic [KAW-1:0] kern_raddr;
  logic [itc_pkg::DATA_W-1:0] next_wdata;

  logic [itc_pkg::IDX_W-1:0]  cell_index;
  logic [itc_pkg::DATA_W-1:0] write_value;
  itc_pkg::req_t              req_type;
  logic                       accept;
  logic                       rd_pend, rd_oor;
  logic [GAW-1:0]             rd_addr, grid_raddr;
  logic                       grid_in_range, kern_in_range;

  assign cell_index    = s_tdata[11:0];
  assign write_value   = s_tdata[43:12];
  assign req_type      = itc_pkg::req_t'(s_tuser);
  assign s_tready      = !ctl.busy && !rd_pend;
  assign accept        = s_tvalid && s_tready;
  assign grid_in_range = 32'(cell_index) < GDEPTH;
  assign kern_in_range = 32'(cell_index) < KDEPTH;

  // Config registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows   <= itc_pkg::RST_GRID_ROWS;
      grid_cols   <= itc_pkg::RST_GRID_COLS;
      kernel_rows <= itc_pkg::RST_KERNEL_ROWS;
      kernel_cols <= itc_pkg::RST_KERNEL_COLS;
      iterations  <= itc_pkg::RST_ITERATIONS;
    end else if (cfg_we) begin
      case (cfg_index)
        itc_pkg::CFG_GRID_ROWS:   grid_rows   <= cfg_data[6:0];
        itc_pkg::CFG_GRID_COLS:   grid_cols   <= cfg_data[6:0];
        itc_pkg::CFG_KERNEL_ROWS: kernel_rows <= cfg_data[2:0];
        itc_pkg::CFG_KERNEL_COLS: kernel_cols <= cfg_data[2:0];
        itc_pkg::CFG_ITERATIONS:  iterations  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Grid read port: sequencer during a run, held address while a read waits, else cell_index
  always_comb begin
    if (ctl.busy)     grid_raddr = seq_graddr;
    else if (rd_pend) grid_raddr = rd_addr;
    else              grid_raddr = GAW'(cell_index);
  end

  always_ff @(posedge clk) begin
    if (ctl.grid_we)
      grid_mem[seq_gwaddr] <= next_q;
    else if (accept && req_type == itc_pkg::REQ_GRID && grid_in_range)
      grid_mem[GAW'(cell_index)] <= write_value;
    grid_q <= grid_mem[grid_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.next_we) next_mem[next_addr] <= next_wdata;
    next_q <= next_mem[next_addr];
  end

  always_ff @(posedge clk) begin
    if (accept && req_type == itc_pkg::REQ_KERNEL && kern_in_range)
      kern_mem[KAW'(cell_index)] <= write_value;
    kern_q <= kern_mem[kern_raddr];
  end

  // Read request: hold the address until the output register frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (rd_pend && (!m_tvalid || m_tready)) begin
        rd_pend  <= 1'b0;
        m_tvalid <= 1'b1;
        m_tdata  <= rd_oor ? '0 : grid_q;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept && req_type == itc_pkg::REQ_READ) begin
        rd_pend <= 1'b1;
        rd_addr <= GAW'(cell_index);
        rd_oor  <= !grid_in_range;
      end
    end
  end

  itc_seq #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .MAX_KDIM (MAX_KDIM),
    .GAW      (GAW),
    .KAW      (KAW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (accept && req_type == itc_pkg::REQ_RUN),
    .grid_rows   (grid_rows),
    .grid_cols   (grid_cols),
    .kernel_rows (kernel_rows),
    .kernel_cols (kernel_cols),
    .iterations  (iterations),
    .grid_q      (grid_q),
    .kern_q      (kern_q),
    .ctl         (ctl),
    .grid_raddr  (seq_graddr),
    .grid_waddr  (seq_gwaddr),
    .kern_raddr  (kern_raddr),
    .next_addr   (next_addr),
    .next_wdata  (next_wdata)
  );

`ifndef ASSERT_OFF
  a_out_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(rd_pend))
    else $error("result beat without a pending read");
  a_copy_in_run: assert property (@(posedge clk) disable iff (rst)
    ctl.grid_we |-> $past(ctl.busy))
    else $error("grid copy outside a run");
  a_no_read_in_run: assert property (@(posedge clk) disable iff (rst)
    ctl.busy |-> !rd_pend)
    else $error("read pending during a run");
`endif

endmodule
